// ===== design/sfd_pkg.sv =====
package sfd_pkg;

    localparam int unsigned MAX_FRAME = 64;   // upper clamp on the frame-length bound
    localparam int unsigned MIN_FRAME = 4;    // lower clamp on the frame-length bound

    localparam logic [7:0] RST_SYNC_PRI  = 8'd238;
    localparam logic [7:0] RST_SYNC_SEC  = 8'd200;
    localparam logic [6:0] RST_MAX_LEN   = 7'd64;
    localparam logic [7:0] RST_CRC_POLY  = 8'd213;
    localparam logic [7:0] RST_CNT_TYPE  = 8'd22;

    localparam logic [15:0] CNT_FULL     = 16'hFFFF;

    typedef enum logic [2:0] {
        REG_SYNC_PRI = 3'd0,
        REG_SYNC_SEC = 3'd1,
        REG_MAX_LEN  = 3'd2,
        REG_CRC_POLY = 3'd3,
        REG_CNT_TYPE = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        STS_IGNORED  = 3'd0,
        STS_TAKEN    = 3'd1,
        STS_GOOD     = 3'd2,
        STS_CRC_FAIL = 3'd3,
        STS_BAD_LEN  = 3'd4,
        STS_OVERRUN  = 3'd5
    } t_status;

    typedef enum logic {
        RX_HUNT  = 1'b0,
        RX_FRAME = 1'b1
    } t_rx_state;

    typedef struct packed {
        logic [7:0] sync_pri;
        logic [7:0] sync_sec;
        logic [6:0] max_eff;    // max_frame_len clamped to MIN_FRAME..MAX_FRAME
        logic [7:0] crc_poly;
        logic [7:0] cnt_type;
    } t_cfg;

    typedef struct packed {
        t_status     status;
        logic [7:0]  byte_out;
        logic [5:0]  byte_index;
        logic [7:0]  frame_type;
        logic [6:0]  frame_length;
        logic [15:0] good_frames;
        logic [15:0] crc_failures;
    } t_result;

    // One byte through an MSB-first CRC-8, init handled by the caller.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ poly;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== design/sfd_cfg.sv =====
module sfd_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [7:0]    i_cfg_data,
    output sfd_pkg::t_cfg o_cfg
);
    import sfd_pkg::*;

    logic [7:0] r_sync_pri;
    logic [7:0] r_sync_sec;
    logic [6:0] r_max_len;
    logic [7:0] r_crc_poly;
    logic [7:0] r_cnt_type;
    logic [6:0] max_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_pri <= RST_SYNC_PRI;
            r_sync_sec <= RST_SYNC_SEC;
            r_max_len  <= RST_MAX_LEN;
            r_crc_poly <= RST_CRC_POLY;
            r_cnt_type <= RST_CNT_TYPE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                REG_SYNC_PRI: r_sync_pri <= i_cfg_data;
                REG_SYNC_SEC: r_sync_sec <= i_cfg_data;
                REG_MAX_LEN:  r_max_len  <= i_cfg_data[6:0];
                REG_CRC_POLY: r_crc_poly <= i_cfg_data;
                REG_CNT_TYPE: r_cnt_type <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_max_len < 7'(MIN_FRAME)) begin
            max_eff = 7'(MIN_FRAME);
        end else if (r_max_len > 7'(MAX_FRAME)) begin
            max_eff = 7'(MAX_FRAME);
        end else begin
            max_eff = r_max_len;
        end
    end

    assign o_cfg.sync_pri = r_sync_pri;
    assign o_cfg.sync_sec = r_sync_sec;
    assign o_cfg.max_eff  = max_eff;
    assign o_cfg.crc_poly = r_crc_poly;
    assign o_cfg.cnt_type = r_cnt_type;

endmodule

// ===== design/sfd_deframe.sv =====
module sfd_deframe (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    input  sfd_pkg::t_cfg    i_cfg,
    output sfd_pkg::t_result o_result
);
    import sfd_pkg::*;

    t_rx_state   r_state, n_state;
    logic [6:0]  r_idx,   n_idx;
    logic [6:0]  r_len,   n_len;
    logic [7:0]  r_crc,   n_crc;
    logic [7:0]  r_type,  n_type;
    logic [15:0] r_good,  n_good;
    logic [15:0] r_bad,   n_bad;

    t_status     status;
    logic [6:0]  pos;
    logic [7:0]  ftype;
    logic [6:0]  flen;

    logic        is_sync;
    logic        overrun;
    logic        bad_len;
    logic        last_byte;

    assign is_sync   = (i_byte == i_cfg.sync_pri) || (i_byte == i_cfg.sync_sec);
    assign overrun   = (r_idx > (i_cfg.max_eff - 7'd1));
    assign bad_len   = (r_idx == 7'd1) &&
                       ((i_byte > {1'b0, i_cfg.max_eff}) || (i_byte < 8'd2));
    // last byte sits at index length + 1; length is already held from index 2 on
    assign last_byte = (r_idx >= 7'd2) && ({1'b0, r_idx} >= ({1'b0, r_len} + 8'd1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            RX_HUNT: begin
                if (is_sync) n_state = RX_FRAME;
            end
            RX_FRAME: begin
                if (overrun || bad_len || last_byte) n_state = RX_HUNT;
            end
            default: n_state = RX_HUNT;
        endcase
    end

    // datapath and result
    always_comb begin
        n_idx  = r_idx;
        n_len  = r_len;
        n_crc  = r_crc;
        n_type = r_type;
        n_good = r_good;
        n_bad  = r_bad;
        status = STS_IGNORED;
        pos    = '0;
        ftype  = '0;
        flen   = '0;
        unique case (r_state)
            RX_HUNT: begin
                if (is_sync) begin
                    n_idx  = 7'd1;
                    n_len  = '0;
                    n_crc  = '0;
                    n_type = '0;
                    status = STS_TAKEN;
                end
            end
            RX_FRAME: begin
                priority if (overrun) begin
                    pos    = r_idx;
                    ftype  = r_type;
                    flen   = r_len;
                    status = STS_OVERRUN;
                    n_idx  = '0;
                    n_len  = '0;
                end else if (bad_len) begin
                    pos    = 7'd1;
                    status = STS_BAD_LEN;
                    n_idx  = '0;
                    n_len  = '0;
                end else begin
                    pos = r_idx;
                    if (r_idx == 7'd1) n_len  = i_byte[6:0];
                    if (r_idx == 7'd2) n_type = i_byte;
                    n_idx = r_idx + 7'd1;
                    ftype = (r_idx >= 7'd2) ? n_type : 8'd0;
                    flen  = n_len;
                    if (last_byte) begin
                        if (r_crc == i_byte) begin
                            status = STS_GOOD;
                            if ((n_type == i_cfg.cnt_type) && (r_good != CNT_FULL)) begin
                                n_good = r_good + 16'd1;
                            end
                        end else begin
                            status = STS_CRC_FAIL;
                            if (r_bad != CNT_FULL) n_bad = r_bad + 16'd1;
                        end
                        n_idx = '0;
                        n_len = '0;
                    end else begin
                        if (r_idx >= 7'd2) n_crc = crc8_step(r_crc, i_byte, i_cfg.crc_poly);
                        status = STS_TAKEN;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RX_HUNT;
            r_idx   <= '0;
            r_len   <= '0;
            r_crc   <= '0;
            r_type  <= '0;
            r_good  <= '0;
            r_bad   <= '0;
        end else if (i_fire) begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_len   <= n_len;
            r_crc   <= n_crc;
            r_type  <= n_type;
            r_good  <= n_good;
            r_bad   <= n_bad;
        end
    end

    assign o_result.status       = status;
    assign o_result.byte_out     = i_byte;
    assign o_result.byte_index   = pos[6] ? 6'h3F : pos[5:0];
    assign o_result.frame_type   = ftype;
    assign o_result.frame_length = flen;
    assign o_result.good_frames  = n_good;
    assign o_result.crc_failures = n_bad;

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= 7'(MAX_FRAME))
        else $error("frame index past bound");

    a_hunt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == RX_HUNT) |-> (r_idx == 7'd0) && (r_len == 7'd0))
        else $error("index or length left over outside a frame");

    a_good_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_good >= $past(r_good)) && (r_bad >= $past(r_bad)))
        else $error("frame counter went backwards");

endmodule

// ===== design/serial_frame_deframer_crc8.sv =====
// Serial frame deframer with CRC-8 check.
//
// Input channel: one received byte per beat on i_rx_byte, qualified by
// i_valid; the block pushes back with o_stall. Output channel: one result
// beat per input beat (status, echoed byte, index, type, length and both
// frame counters), qualified by o_valid; the receiver pushes back with i_stall.
// Configuration: i_cfg_we / i_cfg_index / i_cfg_data write sync bytes, the
// frame-length bound, the CRC polynomial and the counted frame type. Write
// only while no beat is in flight.
//
// Path: a beat accepted into the input register reaches the output through
// one pass of logic and the result register.
// Throughput: one beat per cycle unless the output stalls; the per-byte CRC-8
// update and compare is the longest path between the two registers.
// Reset (synchronous, active low) drops any open frame, zeroes both counters
// and loads the default configuration.
// Stall: with i_stall high a result holds on the output and one more beat
// can still be taken into the input register; o_stall rises only when both
// are full and the output is stalled.
module serial_frame_deframer_crc8 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_byte_out,
    output logic [5:0]  o_byte_index,
    output logic [7:0]  o_frame_type,
    output logic [6:0]  o_frame_length,
    output logic [15:0] o_good_frames,
    output logic [15:0] o_crc_failures,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import sfd_pkg::*;

    t_cfg       cfg;
    t_result    result;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // result register
    logic       r_out_valid;
    t_result    r_out;

    logic       in_accept;
    logic       advance;   // input register beat moves through the deframer

    assign advance   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !advance;
    assign in_accept = i_valid && !o_stall;

    sfd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // frame state lives here; it only steps when a beat advances
    sfd_deframe u_deframe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_byte   (r_in_byte),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out.status;
    assign o_byte_out     = r_out.byte_out;
    assign o_byte_index   = r_out.byte_index;
    assign o_frame_type   = r_out.frame_type;
    assign o_frame_length = r_out.frame_length;
    assign o_good_frames  = r_out.good_frames;
    assign o_crc_failures = r_out.crc_failures;

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid && i_stall)
        else $error("input stalled without a full pipe");

    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("advanced beat lost before the result register");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid && $stable(r_in_byte))
        else $error("held input beat overwritten");

endmodule
